// ----- sv/csmf_pkg.sv -----
// ----------------------------------------------------------------------------
// csmf_pkg
// Shared types and constants of the constant string match filter.
// ----------------------------------------------------------------------------
package csmf_pkg;

  localparam int MAX_SEARCH_BYTES = 32;
  localparam int SEARCH_REGS      = 4;
  localparam int COUNT_W          = 6;
  localparam int ADDR_W           = 6;
  localparam int DATA_W           = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [COUNT_W-1:0] LEN_MAX   = COUNT_W'(MAX_SEARCH_BYTES);

  localparam logic [1:0] MODE_EQUALS   = 2'd0;
  localparam logic [1:0] MODE_STARTS   = 2'd1;
  localparam logic [1:0] MODE_ENDS     = 2'd2;
  localparam logic [1:0] MODE_CONTAINS = 2'd3;

  localparam logic [2:0] REG_MATCH_MODE    = 3'd0;
  localparam logic [2:0] REG_SEARCH_LENGTH = 3'd1;
  localparam logic [2:0] REG_BYTES_0_7     = 3'd2;
  localparam logic [2:0] REG_BYTES_8_15    = 3'd3;
  localparam logic [2:0] REG_BYTES_16_23   = 3'd4;
  localparam logic [2:0] REG_BYTES_24_31   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       row_last;
    logic       row_null;
  } in_item_t;

  typedef struct packed {
    logic match_found;
    logic result_null;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                         match_mode;
    logic [COUNT_W-1:0]                 eff_len;
    logic [MAX_SEARCH_BYTES-1:0][7:0]   search;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bytes_seen;
    logic               prefix_still_equal;
    logic               substring_seen;
    logic               length_exceeded;
    logic               null_seen;
  } row_state_t;

endpackage

// ----- sv/constant_string_match_filter_unit.sv -----
// ----------------------------------------------------------------------------
// constant_string_match_filter_unit
// Matches string rows, one byte per item, against a configured search string.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_stall / item carry one row byte per item,
// with has_byte, row_last and row_null flags. Output channel: result_valid /
// result_stall / result carry one item per row, issued for each input item
// with row_last set. The APB-style port sets the mode, the search length and
// up to 32 search bytes; the user must write only while no row is in flight,
// which the block itself does not enforce. An item passes an input register,
// then the window compare against the aligned search string and the row
// state update, then the result register. One item is accepted every cycle
// while the output is not stalled; the rate is set by the single 32-byte
// window compare. A stalled result holds in the output register; the input
// register keeps accepting until it is full, then item_stall rises.
// Reset clears the configuration to zero, empties both registers and
// returns the row state to the start of a row.
// ----------------------------------------------------------------------------
module constant_string_match_filter_unit
  import csmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  in_item_t   held;
  logic       held_valid;
  logic       out_free;
  logic       go;
  out_item_t  core_result;
  row_state_t state;

  csmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csmf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (held),
    .cfg    (cfg),
    .result (core_result),
    .state  (state)
  );

  assign out_free   = !result_valid || !result_stall;
  assign go         = held_valid && out_free;
  assign item_stall = held_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= go && held.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (go && held.row_last) begin
      result <= core_result;
    end
  end

  a_null_clears_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.match_found && result.result_null))
    else $error("null result with match set");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (go && held.row_last) |=> result_valid)
    else $error("row end gave no result");

  a_row_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (go && held.row_last) |=> (state.bytes_seen == '0 && state.prefix_still_equal &&
                               !state.substring_seen && !state.length_exceeded &&
                               !state.null_seen))
    else $error("row state not cleared after row end");

  a_stall_needs_full_output: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && held_valid))
    else $error("input stalled while output slot free");

endmodule

// ----- sv/csmf_regs.sv -----
// ----------------------------------------------------------------------------
// csmf_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module csmf_regs
  import csmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0]         match_mode;
  logic [COUNT_W-1:0] search_length;
  logic [SEARCH_REGS-1:0][DATA_W-1:0] search_regs;
  logic [2:0]         index;
  logic               wr;

  assign index  = paddr[ADDR_W-1:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode    <= '0;
      search_length <= '0;
      search_regs   <= '0;
    end else if (wr) begin
      case (index)
        REG_MATCH_MODE:    match_mode     <= pwdata[1:0];
        REG_SEARCH_LENGTH: search_length  <= pwdata[COUNT_W-1:0];
        REG_BYTES_0_7:     search_regs[0] <= pwdata;
        REG_BYTES_8_15:    search_regs[1] <= pwdata;
        REG_BYTES_16_23:   search_regs[2] <= pwdata;
        REG_BYTES_24_31:   search_regs[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_MATCH_MODE:    prdata = {{(DATA_W-2){1'b0}}, match_mode};
      REG_SEARCH_LENGTH: prdata = {{(DATA_W-COUNT_W){1'b0}}, search_length};
      REG_BYTES_0_7:     prdata = search_regs[0];
      REG_BYTES_8_15:    prdata = search_regs[1];
      REG_BYTES_16_23:   prdata = search_regs[2];
      REG_BYTES_24_31:   prdata = search_regs[3];
      default:           prdata = '0;
    endcase
  end

  assign cfg.match_mode = match_mode;
  assign cfg.eff_len    = (search_length > LEN_MAX) ? LEN_MAX : search_length;
  assign cfg.search     = search_regs;

endmodule

// ----- sv/csmf_core.sv -----
// ----------------------------------------------------------------------------
// csmf_core
// Row state, byte window and match decision for one item per cycle while go is set.
// ----------------------------------------------------------------------------
module csmf_core
  import csmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  in_item_t   item,
  input  cfg_t       cfg,
  output out_item_t  result,
  output row_state_t state
);

  logic [MAX_SEARCH_BYTES-1:0][7:0] recent_bytes;
  logic [MAX_SEARCH_BYTES-1:0][7:0] recent_bytes_next;
  logic [MAX_SEARCH_BYTES-1:0][7:0] aligned;
  row_state_t state_next;
  row_state_t row;
  logic       win_match;
  logic       match;

  // search string laid out so byte i lines up with the i-th newest row byte
  always_comb begin
    logic [COUNT_W-1:0] idx;
    for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
      idx = cfg.eff_len - COUNT_W'(1) - COUNT_W'(i);
      aligned[i] = cfg.search[idx[4:0]];
    end
  end

  always_comb begin
    logic all_eq;
    row = state;
    recent_bytes_next = recent_bytes;
    if (item.row_null) begin
      row.null_seen = 1'b1;
    end
    if (item.has_byte) begin
      if (state.bytes_seen < cfg.eff_len) begin
        if (item.data_byte != cfg.search[state.bytes_seen[4:0]]) begin
          row.prefix_still_equal = 1'b0;
        end
      end else begin
        row.length_exceeded = 1'b1;
      end
      recent_bytes_next = {recent_bytes[MAX_SEARCH_BYTES-2:0], item.data_byte};
      if (state.bytes_seen != COUNT_MAX) begin
        row.bytes_seen = state.bytes_seen + COUNT_W'(1);
      end
    end
    all_eq = 1'b1;
    for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
      if ((COUNT_W'(i) < cfg.eff_len) && (recent_bytes_next[i] != aligned[i])) begin
        all_eq = 1'b0;
      end
    end
    win_match = all_eq && (row.bytes_seen >= cfg.eff_len);
    if (item.has_byte && win_match) begin
      row.substring_seen = 1'b1;
    end
  end

  always_comb begin
    case (cfg.match_mode)
      MODE_EQUALS:
        match = row.prefix_still_equal && !row.length_exceeded &&
                (row.bytes_seen == cfg.eff_len);
      MODE_STARTS:
        match = row.prefix_still_equal && (row.bytes_seen >= cfg.eff_len);
      MODE_ENDS:
        match = win_match;
      default:
        match = (cfg.eff_len == '0) || row.substring_seen;
    endcase
    result.match_found = match && !row.null_seen;
    result.result_null = row.null_seen;
  end

  always_comb begin
    state_next = row;
    if (item.row_last) begin
      state_next = '{bytes_seen: '0, prefix_still_equal: 1'b1, substring_seen: 1'b0,
                     length_exceeded: 1'b0, null_seen: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{bytes_seen: '0, prefix_still_equal: 1'b1, substring_seen: 1'b0,
                 length_exceeded: 1'b0, null_seen: 1'b0};
      recent_bytes <= '0;
    end else if (go) begin
      state <= state_next;
      recent_bytes <= item.row_last ? '0 : recent_bytes_next;
    end
  end

endmodule
